// ===== rtl/lru_pr_pkg.sv =====
// Shared constants and types for the LRU page replacement unit.
package lru_pr_pkg;

	localparam int FRAMES    = 4;
	localparam int PAGE_BITS = 16;

	localparam int PAGE_W  = 16;
	localparam int SLOT_W  = 2;
	localparam int COUNT_W = 32;

	// Only the low bits of the page number that fit both the port and PAGE_BITS take part.
	localparam int TAG_W  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
	localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	localparam logic [RANK_W-1:0]  RANK_OLDEST = RANK_W'(FRAMES - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

	// Lookup beat broadcast to every cell.
	typedef struct packed {
		logic              active;
		logic [TAG_W-1:0]  page;
		logic              hit;
		logic              fill;
		logic [RANK_W-1:0] hit_rank;
	} lru_bcast_t;

	// Priority link passed from each cell to its higher-index neighbor.
	typedef struct packed {
		logic              match_seen;
		logic [RANK_W-1:0] match_rank;
		logic              empty_seen;
		logic              victim_seen;
		logic [TAG_W-1:0]  victim_page;
	} lru_link_t;

endpackage

// ===== rtl/lru_pr_cell.sv =====
// One frame of the replacement chain: page tag, valid bit and recency age.
module lru_pr_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lru_pr_pkg::lru_bcast_t bcast,
	input  lru_pr_pkg::lru_link_t  link_in,
	output lru_pr_pkg::lru_link_t  link_out,
	output logic                  sel
);
	import lru_pr_pkg::*;

	logic [TAG_W-1:0]  page_q;
	logic              valid_q;
	logic [RANK_W-1:0] rank_q;

	logic match;
	logic empty;
	logic victim;
	logic age;

	assign match  = valid_q && (page_q == bcast.page);
	assign empty  = !valid_q;
	assign victim = valid_q && (rank_q == RANK_OLDEST);

	// Lowest index wins: pass on what the lower cells have already claimed.
	always_comb begin
		link_out.match_seen  = link_in.match_seen | match;
		link_out.match_rank  = link_in.match_seen ? link_in.match_rank : rank_q;
		link_out.empty_seen  = link_in.empty_seen | empty;
		link_out.victim_seen = link_in.victim_seen | victim;
		link_out.victim_page = link_in.victim_seen ? link_in.victim_page : page_q;
	end

	always_comb begin
		priority if (bcast.hit) begin
			sel = match && !link_in.match_seen;
		end else if (bcast.fill) begin
			sel = empty && !link_in.empty_seen;
		end else begin
			sel = victim && !link_in.victim_seen;
		end
	end

	// On a hit only younger frames age; on a fill or eviction every other valid frame ages.
	assign age = !sel && valid_q && (!bcast.hit || (rank_q < bcast.hit_rank));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (bcast.active) begin
			if (sel) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (age) begin
				rank_q <= rank_q + RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bcast.active && sel) begin
			page_q <= bcast.page;
		end
	end

endmodule

// ===== rtl/lru_page_replacement_unit.sv =====
// Top level of the fully associative LRU page replacement unit.
//
// One page reference enters per clock: start is taken whenever busy is low,
// and busy stays low, so a stream of references can be issued back to back.
// Each reference yields exactly one result beat, marked by a done strobe:
// done rises at the clock edge after the accepting one and stays high for a
// single cycle; the receiver cannot stall, so capture it then. The accepting
// edge registers the page number; the next cycle runs the lookup across the
// row of frame cells (the longest path is the priority ripple through all
// FRAMES cells), and at the end of that cycle the tags and ages update and
// the result registers present the beat. A reference sees every earlier
// reference's update. Empty frames fill lowest index first before any
// eviction; after that the least recently used frame is replaced. hit_count
// and miss_count include the current beat and saturate at all ones.
// evicted_page reads zero unless evicted_valid is set. frame_slot carries the
// low two bits of the frame index. Reset clears all frames and counters; no
// clearing pass is needed.
module lru_page_replacement_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [lru_pr_pkg::PAGE_W-1:0]   page_number,
	output logic                            done,
	output logic                            hit,
	output logic [lru_pr_pkg::SLOT_W-1:0]   frame_slot,
	output logic                            evicted_valid,
	output logic [lru_pr_pkg::PAGE_W-1:0]   evicted_page,
	output logic [lru_pr_pkg::COUNT_W-1:0]  hit_count,
	output logic [lru_pr_pkg::COUNT_W-1:0]  miss_count
);
	import lru_pr_pkg::*;

	// Input stage.
	logic              active_s1;
	logic [TAG_W-1:0]  page_s1;

	// Chain wiring.
	lru_bcast_t        bcast;
	lru_link_t         link [FRAMES+1];
	logic [FRAMES-1:0] sel;
	logic [SLOT_W-1:0] slot;
	logic              evict;

	// Result registers and running counters.
	logic               done_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               ev_valid_q;
	logic [PAGE_W-1:0]  ev_page_q;
	logic [COUNT_W-1:0] hits_q;
	logic [COUNT_W-1:0] misses_q;

	// Every cycle is open for a new reference.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_s1 <= 1'b0;
		end else begin
			active_s1 <= start;
		end
	end

	// Drop page bits above the tag width.
	always_ff @(posedge clk) begin
		if (start) begin
			page_s1 <= page_number[TAG_W-1:0];
		end
	end

	// Head of the chain: nothing claimed yet.
	assign link[0] = '0;

	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		lru_pr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bcast    (bcast),
			.link_in  (link[g]),
			.link_out (link[g+1]),
			.sel      (sel[g])
		);
	end

	// The tail of the chain decides hit, fill or evict for the whole row.
	always_comb begin
		bcast.active   = active_s1;
		bcast.page     = page_s1;
		bcast.hit      = link[FRAMES].match_seen;
		bcast.fill     = !link[FRAMES].match_seen && link[FRAMES].empty_seen;
		bcast.hit_rank = link[FRAMES].match_rank;
	end

	assign evict = !bcast.hit && !bcast.fill;

	// Encode the selected frame; only one cell is selected.
	always_comb begin
		slot = '0;
		for (int i = 0; i < FRAMES; i++) begin
			if (sel[i]) begin
				slot = slot | SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			hits_q   <= '0;
			misses_q <= '0;
		end else begin
			done_q <= active_s1;
			if (active_s1) begin
				if (bcast.hit) begin
					if (hits_q != COUNT_MAX) begin
						hits_q <= hits_q + COUNT_W'(1);
					end
				end else if (misses_q != COUNT_MAX) begin
					misses_q <= misses_q + COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_s1) begin
			hit_q      <= bcast.hit;
			slot_q     <= slot;
			ev_valid_q <= evict;
			ev_page_q  <= evict ? PAGE_W'(link[FRAMES].victim_page) : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_slot    = slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign hit_count     = hits_q;
	assign miss_count    = misses_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the fully associative LRU page replacement unit.
module tb;
	import lru_pr_pkg::*;

	localparam int ITEMS       = 1750;
	localparam int IDLE_PCT    = 13;
	// Accepted-beat window in which the sender never idles.
	localparam int CALM_FIRST  = 800;
	localparam int CALM_LAST   = 1100;
	// Slack waited after the drain before the final report.
	localparam int DRAIN_WAIT  = 8;
	localparam logic [PAGE_W-1:0] PAGE_MASK =
		(PAGE_BITS >= PAGE_W) ? {PAGE_W{1'b1}} : PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

	// One expected result beat.
	typedef struct {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               ev_valid;
		logic [PAGE_W-1:0]  ev_page;
		logic [COUNT_W-1:0] hits;
		logic [COUNT_W-1:0] misses;
	} access_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [PAGE_W-1:0]   page_number = '0;
	logic                busy;
	logic                done;
	logic                hit;
	logic [SLOT_W-1:0]   frame_slot;
	logic                evicted_valid;
	logic [PAGE_W-1:0]   evicted_page;
	logic [COUNT_W-1:0]  hit_count;
	logic [COUNT_W-1:0]  miss_count;

	// Page references waiting to be issued, and results still owed by the block.
	logic [PAGE_W-1:0]   ref_q[$];
	access_result_t      owed_q[$];

	// Shadow copy of the frame table.
	bit [PAGE_W-1:0]     shadow_page [FRAMES];
	bit                  shadow_valid[FRAMES];
	int unsigned         shadow_age  [FRAMES];
	bit [COUNT_W-1:0]    shadow_hits;
	bit [COUNT_W-1:0]    shadow_misses;

	int unsigned         issued;
	int unsigned         checked;
	int unsigned         mismatches;
	int unsigned         seen_hits;
	int unsigned         seen_evictions;

	lru_page_replacement_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.page_number   (page_number),
		.done          (done),
		.hit           (hit),
		.frame_slot    (frame_slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.hit_count     (hit_count),
		.miss_count    (miss_count)
	);

	always #5 clk = ~clk;

	// Look the page up in the shadow table, update ages and counters, and
	// return the beat the block must produce for this reference.
	task automatic lru_access(input logic [PAGE_W-1:0] raw, output access_result_t r);
		bit [PAGE_W-1:0] pg;
		int              slot;
		bit              found;
		bit              empty;
		int unsigned     old_age;
		pg      = raw & PAGE_MASK;
		slot    = 0;
		found   = 1'b0;
		empty   = 1'b0;
		old_age = FRAMES;
		r.ev_valid = 1'b0;
		r.ev_page  = '0;
		// Take the lowest matching valid frame.
		for (int i = 0; i < FRAMES; i++) begin
			if (!found && shadow_valid[i] && shadow_page[i] == pg) begin
				slot  = i;
				found = 1'b1;
			end
		end
		if (found) begin
			old_age = shadow_age[slot];
			if (shadow_hits != COUNT_MAX)
				shadow_hits++;
		end else begin
			// Fill the lowest empty frame before evicting anything.
			for (int i = 0; i < FRAMES; i++) begin
				if (!empty && !shadow_valid[i]) begin
					slot  = i;
					empty = 1'b1;
				end
			end
			if (empty) begin
				shadow_valid[slot] = 1'b1;
				old_age = FRAMES;
			end else begin
				// Evict the oldest frame; on a tie keep the lowest index.
				slot    = 0;
				old_age = shadow_age[0];
				for (int i = 1; i < FRAMES; i++) begin
					if (shadow_age[i] > old_age) begin
						old_age = shadow_age[i];
						slot    = i;
					end
				end
				r.ev_valid = 1'b1;
				r.ev_page  = shadow_page[slot];
			end
			shadow_page[slot] = pg;
			if (shadow_misses != COUNT_MAX)
				shadow_misses++;
		end
		// Age every valid frame younger than the touched one; touched becomes newest.
		for (int i = 0; i < FRAMES; i++) begin
			if (i != slot && shadow_valid[i] && shadow_age[i] < old_age)
				shadow_age[i]++;
		end
		shadow_age[slot] = 0;
		r.hit    = found;
		r.slot   = SLOT_W'(slot);
		r.hits   = shadow_hits;
		r.misses = shadow_misses;
	endtask

	task automatic report_field(input string name, input logic [63:0] want,
			input logic [63:0] got, inout bit bad);
		if (want !== got) begin
			bad = 1'b1;
			if (mismatches < 10)
				$display("beat %0d: %s expected %0h, got %0h", checked, name, want, got);
		end
	endtask

	// Driver: hold start until a beat is taken, then load the next reference
	// or idle. Predict on the edge that accepts the beat.
	always @(posedge clk or negedge arst_n) begin
		access_result_t r;
		if (!arst_n) begin
			start       <= 1'b0;
			page_number <= '0;
		end else begin
			if (start && !busy) begin
				lru_access(page_number, r);
				owed_q.push_back(r);
				issued <= issued + 1;
			end
			if (!(start && busy)) begin
				if (ref_q.size() > 0 &&
						!((issued < CALM_FIRST || issued >= CALM_LAST) &&
						$urandom_range(99) < IDLE_PCT)) begin
					start       <= 1'b1;
					page_number <= ref_q.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done strobe must match the oldest owed result.
	always @(posedge clk) begin
		access_result_t w;
		bit bad;
		if (arst_n && done) begin
			if (owed_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result beat: hit %0b slot %0d", hit, frame_slot);
				mismatches++;
			end else begin
				w   = owed_q.pop_front();
				bad = 1'b0;
				report_field("hit",           64'(w.hit),      64'(hit),           bad);
				report_field("frame_slot",    64'(w.slot),     64'(frame_slot),    bad);
				report_field("evicted_valid", 64'(w.ev_valid), 64'(evicted_valid), bad);
				report_field("evicted_page",  64'(w.ev_page),  64'(evicted_page),  bad);
				report_field("hit_count",     64'(w.hits),     64'(hit_count),     bad);
				report_field("miss_count",    64'(w.misses),   64'(miss_count),    bad);
				if (bad)
					mismatches++;
				if (w.hit)
					seen_hits++;
				if (w.ev_valid)
					seen_evictions++;
				checked++;
			end
		end
	end

	// Stimulus: directed references first, then random working sets.
	initial begin
		logic [PAGE_W-1:0] directed[$];
		logic [PAGE_W-1:0] pool[8];
		int                mode;
		int                len;
		int                width;
		issued         = 0;
		checked        = 0;
		mismatches     = 0;
		seen_hits      = 0;
		seen_evictions = 0;
		shadow_hits    = '0;
		shadow_misses  = '0;
		for (int i = 0; i < FRAMES; i++) begin
			shadow_page[i]  = '0;
			shadow_valid[i] = 1'b0;
			shadow_age[i]   = 0;
		end
		// Page zero must miss since reset leaves every frame invalid; then
		// fill the empty frames in order, hit the newest and oldest, and evict.
		directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8001, 16'h7FFE, 16'h0000,
			16'h1234, 16'hFFFF, 16'h7FFE, 16'h5555, 16'hAAAA, 16'hAAAA,
			16'h1234, 16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE, 16'h0001,
			16'h8000, 16'h0001, 16'hFFFE, 16'h5555};
		foreach (directed[i])
			ref_q.push_back(directed[i]);
		while (ref_q.size() < ITEMS) begin
			mode = $urandom_range(99);
			len  = $urandom_range(4, 40);
			for (int i = 0; i < 8; i++)
				pool[i] = PAGE_W'($urandom);
			if (mode < 75) begin
				// Working set: at or under FRAMES gives hits, above it forces evictions.
				width = $urandom_range(2, FRAMES + 3);
				repeat (len)
					ref_q.push_back(pool[$urandom_range(width - 1)]);
			end else if (mode < 90) begin
				// Cyclic sweep one larger than the table: every reference misses.
				for (int i = 0; i < len; i++)
					ref_q.push_back(pool[i % (FRAMES + 1)]);
			end else begin
				repeat (len)
					ref_q.push_back(PAGE_W'($urandom));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain: wait for all references to go out and all results to come back.
		while (ref_q.size() > 0 || start || owed_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("checked %0d result beats from %0d references: %0d hits, %0d evictions",
			checked, issued, seen_hits, seen_evictions);
		if (mismatches == 0 && owed_q.size() == 0) begin
			$display("lru_page_replacement_unit: match");
		end else begin
			$display("%0d mismatching beats", mismatches);
			$display("lru_page_replacement_unit: mismatch");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("timeout with %0d results still owed", owed_q.size());
		$display("lru_page_replacement_unit: mismatch");
		$finish;
	end

endmodule
